// ----- sv/sst_pkg.sv -----
// Package for the script source tokenizer: widths, character codes,
// token kinds, lexer modes and the structs shared by sst_lex and the top level.
// No dependencies.
package sst_pkg;

  localparam int unsigned LookaheadDepth   = 5;
  localparam int unsigned NumberWidth      = 32;
  localparam int unsigned NumberValueWidth = 32;
  localparam int unsigned CntWidth         = $clog2(LookaheadDepth + 1);
  localparam int unsigned DrainWidth       = $clog2(LookaheadDepth + 2);

  localparam logic [7:0] ChSlash   = "/";
  localparam logic [7:0] ChQuote   = "\"";
  localparam logic [7:0] ChZero    = "0";
  localparam logic [7:0] ChNine    = "9";
  localparam logic [7:0] ChEq      = "=";
  localparam logic [7:0] ChLBrace  = "{";
  localparam logic [7:0] ChRBrace  = "}";
  localparam logic [7:0] ChSemi    = ";";
  localparam logic [7:0] ChLParen  = "(";
  localparam logic [7:0] ChRParen  = ")";
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChLowerA  = "a";
  localparam logic [7:0] ChLowerZ  = "z";
  localparam logic [7:0] ChUpperA  = "A";
  localparam logic [7:0] ChUpperZ  = "Z";
  localparam logic [7:0] ChV       = "v";
  localparam logic [7:0] ChO       = "o";
  localparam logic [7:0] ChI       = "i";
  localparam logic [7:0] ChD       = "d";
  localparam logic [7:0] ChN       = "n";
  localparam logic [7:0] ChT       = "t";
  localparam logic [7:0] ChR       = "r";
  localparam logic [7:0] ChE       = "e";
  localparam logic [7:0] ChU       = "u";

  typedef enum logic [3:0] {
    TokString       = 4'd0,
    TokNumber       = 4'd1,
    TokEquals       = 4'd2,
    TokAssign       = 4'd3,
    TokLBrace       = 4'd4,
    TokRBrace       = 4'd5,
    TokSemicolon    = 4'd6,
    TokLParen       = 4'd7,
    TokRParen       = 4'd8,
    TokVoid         = 4'd9,
    TokInt          = 4'd10,
    TokReturn       = 4'd11,
    TokIdent        = 4'd12,
    TokUntermString = 4'd13
  } tok_kind_e;

  typedef enum logic [1:0] {
    ModeNormal  = 2'd0,
    ModeString  = 2'd1,
    ModeComment = 2'd2,
    ModeIdent   = 2'd3
  } lex_mode_e;

  typedef struct packed {
    lex_mode_e              mode;
    logic [2:0]             skip;
    logic [NumberWidth-1:0] acc;
  } lex_state_t;

  typedef struct packed {
    tok_kind_e                   kind;
    logic                        has_char;
    logic [7:0]                  text_char;
    logic                        token_end;
    logic [NumberValueWidth-1:0] number_value;
  } tok_t;

endpackage

// ----- sv/sst_lex.sv -----
// Lexer decision for one source byte given its lookahead bytes and the
// current lexer state; yields at most one token result and the next state.
// Depends on sst_pkg.
module sst_lex (
  input  logic [7:0]                                cur_i,
  input  logic [sst_pkg::LookaheadDepth-1:0][7:0]   la_i,
  input  sst_pkg::lex_state_t                       state_i,
  output sst_pkg::lex_state_t                       state_o,
  output logic                                      tok_valid_o,
  output sst_pkg::tok_t                             tok_o
);

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= sst_pkg::ChLowerA) && (c <= sst_pkg::ChLowerZ)) ||
           ((c >= sst_pkg::ChUpperA) && (c <= sst_pkg::ChUpperZ));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= sst_pkg::ChZero) && (c <= sst_pkg::ChNine);
  endfunction

  function automatic sst_pkg::tok_t mk(sst_pkg::tok_kind_e k, logic hc, logic [7:0] tc,
                                       logic e, logic [sst_pkg::NumberWidth-1:0] n);
    sst_pkg::tok_t t;
    t.kind         = k;
    t.has_char     = hc;
    t.text_char    = tc;
    t.token_end    = e;
    t.number_value = sst_pkg::NumberValueWidth'(n);
    return t;
  endfunction

  logic                            generic;
  logic                            letter_la0;
  logic [sst_pkg::NumberWidth-1:0] acc_next;
  logic [sst_pkg::NumberWidth-1:0] zero_num;

  assign letter_la0 = is_letter(la_i[0]);
  assign zero_num   = '0;
  assign acc_next   = (state_i.acc << 3) + (state_i.acc << 1) +
                      sst_pkg::NumberWidth'(cur_i[3:0]);

  always_comb begin
    state_o     = state_i;
    tok_valid_o = 1'b0;
    tok_o       = mk(sst_pkg::TokString, 1'b0, 8'd0, 1'b0, zero_num);
    generic     = 1'b0;
    if (state_i.skip != 3'd0) begin
      state_o.skip = state_i.skip - 3'd1;
    end else begin
      unique case (state_i.mode)
        sst_pkg::ModeComment: begin
          if (cur_i == sst_pkg::ChNewline) state_o.mode = sst_pkg::ModeNormal;
        end
        sst_pkg::ModeString: begin
          tok_valid_o = 1'b1;
          if (cur_i == sst_pkg::ChQuote) begin
            state_o.mode = sst_pkg::ModeNormal;
            tok_o        = mk(sst_pkg::TokString, 1'b0, 8'd0, 1'b1, zero_num);
          end else begin
            tok_o = mk(sst_pkg::TokString, 1'b1, cur_i, 1'b0, zero_num);
          end
        end
        sst_pkg::ModeIdent: begin
          if (is_letter(cur_i)) begin
            tok_valid_o = 1'b1;
            tok_o       = mk(sst_pkg::TokIdent, 1'b1, cur_i, !letter_la0, zero_num);
            if (!letter_la0) state_o.mode = sst_pkg::ModeNormal;
          end else begin
            state_o.mode = sst_pkg::ModeNormal;
            generic      = 1'b1;
          end
        end
        default: generic = 1'b1;
      endcase
    end

    if (generic) begin
      tok_valid_o = 1'b1;
      if (cur_i == sst_pkg::ChSlash && la_i[0] == sst_pkg::ChSlash) begin
        tok_valid_o  = 1'b0;
        state_o.mode = sst_pkg::ModeComment;
      end else if (cur_i == sst_pkg::ChQuote) begin
        tok_valid_o  = 1'b0;
        state_o.mode = sst_pkg::ModeString;
      end else if (is_digit(cur_i)) begin
        if (!is_digit(la_i[0])) begin
          tok_o       = mk(sst_pkg::TokNumber, 1'b0, 8'd0, 1'b1, acc_next);
          state_o.acc = '0;
        end else begin
          tok_valid_o = 1'b0;
          state_o.acc = acc_next;
        end
      end else if (cur_i == sst_pkg::ChEq) begin
        if (la_i[0] == sst_pkg::ChEq) begin
          tok_o        = mk(sst_pkg::TokEquals, 1'b0, 8'd0, 1'b1, zero_num);
          state_o.skip = 3'd1;
        end else begin
          tok_o = mk(sst_pkg::TokAssign, 1'b0, 8'd0, 1'b1, zero_num);
        end
      end else if (cur_i == sst_pkg::ChLBrace) begin
        tok_o = mk(sst_pkg::TokLBrace, 1'b0, 8'd0, 1'b1, zero_num);
      end else if (cur_i == sst_pkg::ChRBrace) begin
        tok_o = mk(sst_pkg::TokRBrace, 1'b0, 8'd0, 1'b1, zero_num);
      end else if (cur_i == sst_pkg::ChSemi) begin
        tok_o = mk(sst_pkg::TokSemicolon, 1'b0, 8'd0, 1'b1, zero_num);
      end else if (cur_i == sst_pkg::ChLParen) begin
        tok_o = mk(sst_pkg::TokLParen, 1'b0, 8'd0, 1'b1, zero_num);
      end else if (cur_i == sst_pkg::ChRParen) begin
        tok_o = mk(sst_pkg::TokRParen, 1'b0, 8'd0, 1'b1, zero_num);
      end else if (cur_i == sst_pkg::ChV && la_i[0] == sst_pkg::ChO &&
                   la_i[1] == sst_pkg::ChI && la_i[2] == sst_pkg::ChD) begin
        tok_o        = mk(sst_pkg::TokVoid, 1'b0, 8'd0, 1'b1, zero_num);
        state_o.skip = 3'd3;
      end else if (cur_i == sst_pkg::ChI && la_i[0] == sst_pkg::ChN &&
                   la_i[1] == sst_pkg::ChT) begin
        tok_o        = mk(sst_pkg::TokInt, 1'b0, 8'd0, 1'b1, zero_num);
        state_o.skip = 3'd2;
      end else if (cur_i == sst_pkg::ChR && la_i[0] == sst_pkg::ChE &&
                   la_i[1] == sst_pkg::ChT && la_i[2] == sst_pkg::ChU &&
                   la_i[3] == sst_pkg::ChR && la_i[4] == sst_pkg::ChN) begin
        tok_o        = mk(sst_pkg::TokReturn, 1'b0, 8'd0, 1'b1, zero_num);
        state_o.skip = 3'd5;
      end else if (is_letter(cur_i)) begin
        tok_o = mk(sst_pkg::TokIdent, 1'b1, cur_i, !letter_la0, zero_num);
        if (letter_la0) state_o.mode = sst_pkg::ModeIdent;
      end else begin
        tok_valid_o = 1'b0;
      end
    end
  end

endmodule

// ----- sv/script_source_tokenizer.sv -----
// Top level of the script source tokenizer: lookahead window, end-of-source
// drain sequencer, result holding stage and output register.
// Depends on sst_pkg and sst_lex.
//
//   channel | signals                                      | direction
//   in      | in_valid_i, in_ready_o, ch_i, end_of_source_i | source bytes in
//   out     | out_valid_o, out_ready_i, kind_o, has_char_o,  | token results out
//           | text_char_o, token_end_o, number_value_o, last_o |
//
// A byte without end_of_source fills the window; once it is full, the window decides its oldest
// byte as the new byte arrives, giving at most one result straight into the output register.
// A byte with end_of_source starts the drain: after the transfer, one drain step of the lexer
// per window entry, then a tail step and a flush step; input is held off.
// Reset clears the window, the lexer state and all valid flags.
// A stalled output holds the input off, and holds the drain, tail and flush steps whenever a held result must move on.
module script_source_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic        has_char_o,
  output logic [7:0]  text_char_o,
  output logic        token_end_o,
  output logic [31:0] number_value_o,
  output logic        last_o
);

  localparam int unsigned La = sst_pkg::LookaheadDepth;

  typedef enum logic [3:0] {
    SRun   = 4'b0001,
    SDrain = 4'b0010,
    STail  = 4'b0100,
    SFlush = 4'b1000
  } seq_state_e;

  seq_state_e                       st_q, st_d;
  logic [7:0]                       win_q [La+1];
  logic [7:0]                       win_d [La+1];
  logic [sst_pkg::CntWidth-1:0]     cnt_q, cnt_d;
  logic [sst_pkg::DrainWidth-1:0]   dcnt_q, dcnt_d;
  sst_pkg::lex_state_t              lex_q, lex_d, lex_nxt, lex_rst;
  sst_pkg::tok_t                    hold_q, hold_d;
  logic                             hold_v_q, hold_v_d;
  sst_pkg::tok_t                    out_q, out_d;
  logic                             out_last_q, out_last_d;
  logic                             out_valid_q, out_valid_d;

  logic [La-1:0][7:0]               la;
  logic                             lex_tok_v;
  sst_pkg::tok_t                    lex_tok;
  sst_pkg::tok_t                    tail_tok;
  logic                             out_free;
  logic                             acc_in;
  logic                             need_push;
  logic                             push;
  sst_pkg::tok_t                    push_tok;
  logic                             push_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == SRun) && out_free;
  assign acc_in     = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < La; k++) begin
      if (st_q == SRun && k == La - 1) la[k] = ch_i;
      else                             la[k] = win_q[k+1];
    end
  end

  sst_lex u_lex (
    .cur_i       (win_q[0]),
    .la_i        (la),
    .state_i     (lex_q),
    .state_o     (lex_nxt),
    .tok_valid_o (lex_tok_v),
    .tok_o       (lex_tok)
  );

  always_comb begin
    lex_rst.mode = sst_pkg::ModeNormal;
    lex_rst.skip = 3'd0;
    lex_rst.acc  = '0;

    tail_tok.kind         = sst_pkg::TokUntermString;
    tail_tok.has_char     = 1'b0;
    tail_tok.text_char    = 8'd0;
    tail_tok.token_end    = 1'b1;
    tail_tok.number_value = '0;
  end

  always_comb begin
    st_d      = st_q;
    win_d     = win_q;
    cnt_d     = cnt_q;
    dcnt_d    = dcnt_q;
    lex_d     = lex_q;
    hold_d    = hold_q;
    hold_v_d  = hold_v_q;
    need_push = 1'b0;
    push      = 1'b0;
    push_tok  = lex_tok;
    push_last = 1'b1;

    unique case (st_q)
      SRun: begin
        if (acc_in) begin
          if (!end_of_source_i) begin
            if (cnt_q < sst_pkg::CntWidth'(La)) begin
              for (int j = 0; j < La; j++) begin
                if (cnt_q == sst_pkg::CntWidth'(j)) win_d[j] = ch_i;
              end
              cnt_d = cnt_q + 1'b1;
            end else begin
              lex_d = lex_nxt;
              for (int j = 0; j < La - 1; j++) win_d[j] = win_q[j+1];
              win_d[La-1] = ch_i;
              push        = lex_tok_v;
            end
          end else begin
            for (int j = 0; j <= La; j++) begin
              if (sst_pkg::CntWidth'(j) < cnt_q)       win_d[j] = win_q[j];
              else if (sst_pkg::CntWidth'(j) == cnt_q) win_d[j] = ch_i;
              else                                     win_d[j] = 8'd0;
            end
            dcnt_d = sst_pkg::DrainWidth'(cnt_q) + 1'b1;
            st_d   = SDrain;
          end
        end
      end
      SDrain: begin
        need_push = lex_tok_v && hold_v_q;
        if (!need_push || out_free) begin
          lex_d = lex_nxt;
          for (int j = 0; j < La; j++) win_d[j] = win_q[j+1];
          win_d[La] = 8'd0;
          dcnt_d    = dcnt_q - 1'b1;
          if (lex_tok_v) begin
            hold_d   = lex_tok;
            hold_v_d = 1'b1;
          end
          push      = need_push;
          push_tok  = hold_q;
          push_last = 1'b0;
          if (dcnt_q == sst_pkg::DrainWidth'(1)) st_d = STail;
        end
      end
      STail: begin
        need_push = (lex_q.mode == sst_pkg::ModeString) && hold_v_q;
        if (!need_push || out_free) begin
          if (lex_q.mode == sst_pkg::ModeString) begin
            hold_d   = tail_tok;
            hold_v_d = 1'b1;
          end
          push      = need_push;
          push_tok  = hold_q;
          push_last = 1'b0;
          st_d      = SFlush;
        end
      end
      SFlush: begin
        if (!hold_v_q || out_free) begin
          push      = hold_v_q;
          push_tok  = hold_q;
          push_last = 1'b1;
          hold_v_d  = 1'b0;
          lex_d     = lex_rst;
          cnt_d     = '0;
          for (int j = 0; j <= La; j++) win_d[j] = 8'd0;
          st_d      = SRun;
        end
      end
      default: st_d = SRun;
    endcase
  end

  always_comb begin
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push) begin
      out_d       = push_tok;
      out_last_d  = push_last;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= SRun;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      lex_q       <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j <= La; j++) win_q[j] <= 8'd0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      lex_q       <= lex_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign has_char_o     = out_q.has_char;
  assign text_char_o    = out_q.text_char;
  assign token_end_o    = out_q.token_end;
  assign number_value_o = out_q.number_value;
  assign last_o         = out_last_q;

  a_eos_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && end_of_source_i) |=> (st_q == SDrain && !in_ready_o))
    else $error("end-of-source transfer did not start the drain");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SDrain) |-> (dcnt_q != '0))
    else $error("drain running with no bytes left");

  a_flush_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SFlush && hold_v_q && !out_free) |=> (st_q == SFlush && hold_v_q))
    else $error("held result dropped while output stalled");

  a_window_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sst_pkg::CntWidth'(La))
    else $error("window fill count beyond depth");

endmodule
